/* sv/nmea_rmc_field_extractor_top_defines.svh */
// assertion helpers for the rmc extractor emit module
`ifndef NMEA_RMC_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define RMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define RMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nmea_rmc_pkg.sv */
package nmea_rmc_pkg;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_VOID   = 8'h56;

    localparam int HDR_LEN = 6;

    // field ids on the result stream
    localparam logic [2:0] FID_LAT    = 3'd0;
    localparam logic [2:0] FID_LATDIR = 3'd1;
    localparam logic [2:0] FID_LON    = 3'd2;
    localparam logic [2:0] FID_LONDIR = 3'd3;
    localparam logic [2:0] FID_SPD    = 3'd4;
    localparam logic [2:0] FID_CRS    = 3'd5;

    // comma count that opens each field of interest
    localparam logic [3:0] CC_STATUS = 4'd2;
    localparam logic [3:0] CC_LAT    = 4'd3;
    localparam logic [3:0] CC_LATDIR = 4'd4;
    localparam logic [3:0] CC_LON    = 4'd5;
    localparam logic [3:0] CC_LONDIR = 4'd6;
    localparam logic [3:0] CC_SPD    = 4'd7;
    localparam logic [3:0] CC_CRS    = 4'd8;
    localparam logic [3:0] CNT_SAT   = 4'hF;

    localparam int LAT_LEN = 9;
    localparam int LON_LEN = 10;

    // capture memory layout; course follows speed at SPD_BASE + FIELD_MAX
    localparam int LAT_BASE    = 0;
    localparam int LATDIR_BASE = 9;
    localparam int LON_BASE    = 10;
    localparam int LONDIR_BASE = 20;
    localparam int SPD_BASE    = 21;

    typedef struct packed {
        logic we;
        logic clr;
    } cap_ctl_t;

    typedef struct packed {
        logic       start;
        logic [3:0] speed_len;
        logic [3:0] course_len;
    } emit_req_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_LOAD
    } emit_state_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* sv/nmea_rmc_parse.sv */
module nmea_rmc_parse
    import nmea_rmc_pkg::*;
#(
    parameter int MAX_SENTENCE = 100,
    parameter int FIELD_MAX    = 8,
    parameter int AW           = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    rx_byte,
    output cap_ctl_t      cap_ctl,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output emit_req_t     req
);

    localparam int CRS_BASE = SPD_BASE + FIELD_MAX;

    logic       in_sentence_reg, in_sentence_next;
    logic       header_match_reg, header_match_next;
    logic [6:0] byte_count_reg, byte_count_next;
    logic [3:0] comma_count_reg, comma_count_next;
    logic [3:0] pos_reg, pos_next;
    logic       status_void_reg, status_void_next;
    logic [3:0] speed_len_reg, speed_len_next;
    logic [3:0] course_len_reg, course_len_next;

    // view of the state after a '$' has restarted the sentence
    logic       is_dollar;
    logic       cur_in, cur_hm, cur_sv;
    logic [6:0] cur_bc;
    logic [3:0] cur_cc, cur_pos, cur_spd, cur_crs;

    always_comb begin
        is_dollar = in_fire && (rx_byte == CH_DOLLAR);
        cur_in    = is_dollar || in_sentence_reg;
        cur_hm    = is_dollar || header_match_reg;
        cur_bc    = is_dollar ? '0 : byte_count_reg;
        cur_cc    = is_dollar ? '0 : comma_count_reg;
        cur_pos   = is_dollar ? '0 : pos_reg;
        cur_sv    = is_dollar ? 1'b0 : status_void_reg;
        cur_spd   = is_dollar ? '0 : speed_len_reg;
        cur_crs   = is_dollar ? '0 : course_len_reg;
    end

    always_comb begin
        in_sentence_next  = in_sentence_reg;
        header_match_next = header_match_reg;
        byte_count_next   = byte_count_reg;
        comma_count_next  = comma_count_reg;
        pos_next          = pos_reg;
        status_void_next  = status_void_reg;
        speed_len_next    = speed_len_reg;
        course_len_next   = course_len_reg;
        cap_ctl           = '0;
        wr_addr           = '0;
        wr_data           = rx_byte;
        req.start         = 1'b0;

        if (in_fire) begin
            cap_ctl.clr       = is_dollar;
            in_sentence_next  = cur_in;
            header_match_next = cur_hm;
            byte_count_next   = cur_bc;
            comma_count_next  = cur_cc;
            pos_next          = cur_pos;
            status_void_next  = cur_sv;
            speed_len_next    = cur_spd;
            course_len_next   = cur_crs;

            if (cur_in) begin
                if (cur_bc >= 7'(MAX_SENTENCE)) begin
                    // overlong: drop the sentence silently
                    in_sentence_next = 1'b0;
                end else begin
                    if (cur_bc < 7'(HDR_LEN) && rx_byte != hdr_char(cur_bc[2:0])) begin
                        header_match_next = 1'b0;
                    end
                    byte_count_next = cur_bc + 7'd1;

                    if (rx_byte == CH_NL) begin
                        in_sentence_next = 1'b0;
                        req.start = header_match_next && (byte_count_next >= 7'(HDR_LEN))
                                    && (cur_cc >= CC_CRS) && !cur_sv;
                    end else if (rx_byte == CH_COMMA) begin
                        if (cur_cc != CNT_SAT) begin
                            comma_count_next = cur_cc + 4'd1;
                        end
                        pos_next = '0;
                    end else if (!is_dollar) begin
                        case (cur_cc)
                            CC_STATUS: begin
                                if (cur_pos == '0 && rx_byte == CH_VOID) begin
                                    status_void_next = 1'b1;
                                end
                            end
                            CC_LAT: begin
                                cap_ctl.we = cur_pos < 4'(LAT_LEN);
                                wr_addr    = AW'(LAT_BASE) + AW'(cur_pos);
                            end
                            CC_LATDIR: begin
                                cap_ctl.we = cur_pos == '0;
                                wr_addr    = AW'(LATDIR_BASE);
                            end
                            CC_LON: begin
                                cap_ctl.we = cur_pos < 4'(LON_LEN);
                                wr_addr    = AW'(LON_BASE) + AW'(cur_pos);
                            end
                            CC_LONDIR: begin
                                cap_ctl.we = cur_pos == '0;
                                wr_addr    = AW'(LONDIR_BASE);
                            end
                            CC_SPD: begin
                                wr_addr = AW'(SPD_BASE) + AW'(cur_pos);
                                if (cur_pos < 4'(FIELD_MAX)) begin
                                    cap_ctl.we     = 1'b1;
                                    speed_len_next = cur_pos + 4'd1;
                                end
                            end
                            CC_CRS: begin
                                wr_addr = AW'(CRS_BASE) + AW'(cur_pos);
                                if (cur_pos < 4'(FIELD_MAX)) begin
                                    cap_ctl.we      = 1'b1;
                                    course_len_next = cur_pos + 4'd1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (cur_pos != CNT_SAT) begin
                            pos_next = cur_pos + 4'd1;
                        end
                    end
                end
            end
        end

        req.speed_len  = speed_len_next;
        req.course_len = course_len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg  <= 1'b0;
            header_match_reg <= 1'b0;
            byte_count_reg   <= '0;
            comma_count_reg  <= '0;
            pos_reg          <= '0;
            status_void_reg  <= 1'b0;
            speed_len_reg    <= '0;
            course_len_reg   <= '0;
        end else begin
            in_sentence_reg  <= in_sentence_next;
            header_match_reg <= header_match_next;
            byte_count_reg   <= byte_count_next;
            comma_count_reg  <= comma_count_next;
            pos_reg          <= pos_next;
            status_void_reg  <= status_void_next;
            speed_len_reg    <= speed_len_next;
            course_len_reg   <= course_len_next;
        end
    end

endmodule

/* sv/nmea_rmc_cap_mem.sv */
module nmea_rmc_cap_mem
    import nmea_rmc_pkg::*;
#(
    parameter int DEPTH = 37,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cap_ctl_t      cap_ctl,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (cap_ctl.we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    // unwritten entries since the last '$' read back as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cap_ctl.clr) begin
            valid_reg <= '0;
        end else if (cap_ctl.we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 8'h00;

endmodule

/* sv/nmea_rmc_emit.sv */
`include "nmea_rmc_field_extractor_top_defines.svh"

module nmea_rmc_emit
    import nmea_rmc_pkg::*;
#(
    parameter int FIELD_MAX = 8,
    parameter int DEPTH     = 37,
    parameter int AW        = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  emit_req_t     req,
    output logic          busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tlast
);

    localparam int CRS_BASE = SPD_BASE + FIELD_MAX;

    emit_state_t state_reg, state_next;
    logic [2:0]  fid_reg, fid_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  spd_len_reg, spd_len_next;
    logic [3:0]  crs_len_reg, crs_len_next;

    // tags of the word in flight through the memory read
    logic [2:0]  p_fid_reg;
    logic [3:0]  p_idx_reg;
    logic        p_last_reg;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_fid_reg;
    logic [3:0]  m_idx_reg;
    logic [7:0]  m_code_reg;
    logic        m_last_reg;

    logic        load;
    logic [2:0]  step_fid;
    logic [3:0]  step_idx;
    logic        step_last;

    // walk order: lat, lat dir, lon, lon dir, speed, course
    always_comb begin
        step_fid  = fid_reg;
        step_idx  = idx_reg + 4'd1;
        step_last = 1'b0;
        rd_addr   = '0;
        case (fid_reg)
            FID_LAT: begin
                rd_addr = AW'(LAT_BASE) + AW'(idx_reg);
                if (idx_reg == 4'(LAT_LEN - 1)) begin
                    step_fid = FID_LATDIR;
                    step_idx = '0;
                end
            end
            FID_LATDIR: begin
                rd_addr  = AW'(LATDIR_BASE);
                step_fid = FID_LON;
                step_idx = '0;
            end
            FID_LON: begin
                rd_addr = AW'(LON_BASE) + AW'(idx_reg);
                if (idx_reg == 4'(LON_LEN - 1)) begin
                    step_fid = FID_LONDIR;
                    step_idx = '0;
                end
            end
            FID_LONDIR: begin
                rd_addr  = AW'(LONDIR_BASE);
                step_idx = '0;
                if (spd_len_reg != '0) begin
                    step_fid = FID_SPD;
                end else if (crs_len_reg != '0) begin
                    step_fid = FID_CRS;
                end else begin
                    step_last = 1'b1;
                end
            end
            FID_SPD: begin
                rd_addr = AW'(SPD_BASE) + AW'(idx_reg);
                if (idx_reg == spd_len_reg - 4'd1) begin
                    step_idx = '0;
                    if (crs_len_reg != '0) begin
                        step_fid = FID_CRS;
                    end else begin
                        step_last = 1'b1;
                    end
                end
            end
            FID_CRS: begin
                rd_addr   = AW'(CRS_BASE) + AW'(idx_reg);
                step_last = idx_reg == crs_len_reg - 4'd1;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        fid_next     = fid_reg;
        idx_next     = idx_reg;
        spd_len_next = spd_len_reg;
        crs_len_next = crs_len_reg;
        rd_en        = 1'b0;
        load         = 1'b0;
        case (state_reg)
            EM_IDLE: begin
                if (req.start) begin
                    fid_next     = FID_LAT;
                    idx_next     = '0;
                    spd_len_next = req.speed_len;
                    crs_len_next = req.course_len;
                    state_next   = EM_READ;
                end
            end
            EM_READ: begin
                // output word must be free when the read data lands
                if (!m_valid_reg || m_tready) begin
                    rd_en      = 1'b1;
                    fid_next   = step_fid;
                    idx_next   = step_idx;
                    state_next = EM_LOAD;
                end
            end
            EM_LOAD: begin
                load       = 1'b1;
                state_next = p_last_reg ? EM_IDLE : EM_READ;
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fid_reg     <= fid_next;
        idx_reg     <= idx_next;
        spd_len_reg <= spd_len_next;
        crs_len_reg <= crs_len_next;
        if (rd_en) begin
            p_fid_reg  <= fid_reg;
            p_idx_reg  <= idx_reg;
            p_last_reg <= step_last;
        end
        if (load) begin
            m_fid_reg  <= p_fid_reg;
            m_idx_reg  <= p_idx_reg;
            m_code_reg <= rd_data;
            m_last_reg <= p_last_reg;
        end
    end

    assign busy     = state_reg != EM_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_code_reg, m_idx_reg, m_fid_reg};
    assign m_tlast  = m_last_reg;

    `RMC_ASSERT_IMP(a_start_idle, req.start, state_reg == EM_IDLE, "run requested while emitting")
    `RMC_ASSERT_IMP(a_load_free, state_reg == EM_LOAD, !m_valid_reg, "output word busy on load")
    `RMC_ASSERT_NXT(a_load_shows, state_reg == EM_LOAD, m_valid_reg, "loaded word not shown")
    `RMC_ASSERT_IMP(a_rd_range, rd_en, rd_addr < AW'(DEPTH), "capture read out of range")

endmodule

/* sv/nmea_rmc_field_extractor_top.sv */
// NMEA 0183 RMC field extractor. Takes received characters on s_tdata and, for each
// "$GPRMC" sentence with at least eight commas and a status not starting with 'V', emits
// on the newline the raw latitude (9), latitude direction (1), longitude (10), longitude
// direction (1), speed and course characters (each up to FIELD_MAX) as words tagged with
// field id and position; m_tlast marks the final word of the run. Captures are kept in a
// small byte memory with per-entry valid bits cleared at each '$'. Outside emission one
// character is taken every cycle. After an accepted sentence the input stalls while the
// run is read out: 21 + speed length + course length words, each one memory read then one
// output load, longer when m_tready is held low. Only the final word can wait in the
// output register while the next sentence is already being taken. Sentences longer than
// MAX_SENTENCE characters are dropped.
module nmea_rmc_field_extractor_top
    import nmea_rmc_pkg::*;
#(
    parameter int MAX_SENTENCE = 100,
    parameter int FIELD_MAX    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] field_id, [6:3] char_index, [14:7] char_code
    output logic        m_tlast
);

    localparam int DEPTH = SPD_BASE + 2 * FIELD_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic          in_fire;
    logic          busy;
    cap_ctl_t      cap_ctl;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    emit_req_t     req;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    nmea_rmc_parse #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .FIELD_MAX    (FIELD_MAX),
        .AW           (AW)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .cap_ctl (cap_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req)
    );

    nmea_rmc_cap_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cap_ctl (cap_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nmea_rmc_emit #(
        .FIELD_MAX (FIELD_MAX),
        .DEPTH     (DEPTH),
        .AW        (AW)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
